// ===== rtl/dotq_pkg.sv =====
package dotq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TAG_BITS    = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int TIME_W      = 48;
  localparam int ID_W        = 16;
  localparam int DELAY_W     = 32;

  localparam logic [DELAY_W-1:0] IDLE_RESET = 32'd30000000;

  typedef logic [TIME_W-1:0]   tstamp_t;
  typedef logic [ID_W-1:0]     id_t;
  typedef logic [TAG_BITS-1:0] tag_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [DELAY_W-1:0]  delay_t;

  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_POLL = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_ADDED = 2'd0,
    ST_FIRED = 2'd1,
    ST_WAIT  = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RK_ADDED = 2'd0,
    RK_FULL  = 2'd1,
    RK_IDLE  = 2'd2,
    RK_POLL  = 2'd3
  } res_kind_t;

  typedef struct packed {
    tstamp_t dl;
    tag_t    tag;
  } entry_t;

  typedef struct packed {
    logic      in_ready;
    logic      ld_item;
    logic      rd_en;
    logic      rd_head;
    logic      wr_en;
    logic      wr_item;
    logic      k_dec;
    logic      cnt_inc;
    logic      res_ld;
    res_kind_t res_kind;
    logic      out_push;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic item_poll;
    logic cnt_zero;
    logic full;
    logic k_one;
    logic rd_gt;
    logic out_free;
  } ctrl_sts_t;

  // physical slot of a logical offset from the head, wrapping at the depth
  function automatic idx_t wrap_idx(idx_t head, cnt_t off);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(head) + (CNT_W + 1)'(off);
    if (s >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
      s = s - (CNT_W + 1)'(QUEUE_DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic tag_t id_to_tag(id_t id);
    logic [63:0] w;
    w = 64'(id);
    return w[TAG_BITS-1:0];
  endfunction

  function automatic id_t tag_to_id(tag_t tag);
    logic [63:0] w;
    w = 64'(tag);
    return w[ID_W-1:0];
  endfunction

endpackage

// ===== rtl/dotq_if.sv =====
interface dotq_in_if;
  logic              valid;
  logic              ready;
  dotq_pkg::cmd_t    cmd;
  dotq_pkg::tstamp_t deadline;
  dotq_pkg::id_t     event_id;
  dotq_pkg::tstamp_t now_time;

  modport source (output valid, cmd, deadline, event_id, now_time, input ready);
  modport sink   (input valid, cmd, deadline, event_id, now_time, output ready);
endinterface

interface dotq_out_if;
  logic              valid;
  logic              ready;
  dotq_pkg::status_t status;
  dotq_pkg::id_t     fired_id;
  dotq_pkg::tstamp_t fired_time;
  dotq_pkg::tstamp_t wait_delay;

  modport source (output valid, status, fired_id, fired_time, wait_delay, input ready);
  modport sink   (input valid, status, fired_id, fired_time, wait_delay, output ready);
endinterface

interface dotq_cfg_if;
  logic             valid;
  logic             ready;
  dotq_pkg::delay_t data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/dotq_ctrl.sv =====
module dotq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  dotq_pkg::ctrl_sts_t sts_i,
  output dotq_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_DISP      = 6'b000010,
    S_ADD_EVAL  = 6'b000100,
    S_ADD_PUT   = 6'b001000,
    S_POLL_EVAL = 6'b010000,
    S_DONE      = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    cmd_o.res_kind = dotq_pkg::RK_ADDED;
    unique case (state_r)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_valid) begin
          cmd_o.ld_item = 1'b1;
          state_nxt     = S_DISP;
        end
      end
      S_DISP: begin
        if (sts_i.item_poll) begin
          if (sts_i.cnt_zero) begin
            cmd_o.res_ld   = 1'b1;
            cmd_o.res_kind = dotq_pkg::RK_IDLE;
            state_nxt      = S_DONE;
          end else begin
            cmd_o.rd_en   = 1'b1;
            cmd_o.rd_head = 1'b1;
            state_nxt     = S_POLL_EVAL;
          end
        end else if (sts_i.full) begin
          cmd_o.res_ld   = 1'b1;
          cmd_o.res_kind = dotq_pkg::RK_FULL;
          state_nxt      = S_DONE;
        end else if (sts_i.cnt_zero) begin
          cmd_o.wr_en    = 1'b1;
          cmd_o.wr_item  = 1'b1;
          cmd_o.cnt_inc  = 1'b1;
          cmd_o.res_ld   = 1'b1;
          cmd_o.res_kind = dotq_pkg::RK_ADDED;
          state_nxt      = S_DONE;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_nxt   = S_ADD_EVAL;
        end
      end
      S_ADD_EVAL: begin
        // walk from the tail, moving later deadlines up one slot
        if (sts_i.rd_gt) begin
          cmd_o.wr_en = 1'b1;
          cmd_o.k_dec = 1'b1;
          if (sts_i.k_one) begin
            state_nxt = S_ADD_PUT;
          end else begin
            cmd_o.rd_en = 1'b1;
          end
        end else begin
          cmd_o.wr_en    = 1'b1;
          cmd_o.wr_item  = 1'b1;
          cmd_o.cnt_inc  = 1'b1;
          cmd_o.res_ld   = 1'b1;
          cmd_o.res_kind = dotq_pkg::RK_ADDED;
          state_nxt      = S_DONE;
        end
      end
      S_ADD_PUT: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_item  = 1'b1;
        cmd_o.cnt_inc  = 1'b1;
        cmd_o.res_ld   = 1'b1;
        cmd_o.res_kind = dotq_pkg::RK_ADDED;
        state_nxt      = S_DONE;
      end
      S_POLL_EVAL: begin
        cmd_o.res_ld   = 1'b1;
        cmd_o.res_kind = dotq_pkg::RK_POLL;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_push = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/dotq_dp.sv =====
module dotq_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  dotq_pkg::ctrl_cmd_t cmd_i,
  output dotq_pkg::ctrl_sts_t sts_o,
  dotq_in_if.sink             in_chan,
  dotq_out_if.source          out_chan,
  dotq_cfg_if.sink            cfg_chan
);

  dotq_pkg::entry_t  mem [dotq_pkg::QUEUE_DEPTH];
  dotq_pkg::entry_t  rd_r;

  dotq_pkg::cmd_t    item_cmd_r;
  dotq_pkg::tstamp_t item_dl_r;
  dotq_pkg::tag_t    item_tag_r;
  dotq_pkg::tstamp_t item_now_r;

  dotq_pkg::cnt_t    cnt_r, cnt_nxt;
  dotq_pkg::idx_t    head_r, head_nxt;
  dotq_pkg::cnt_t    k_r, k_nxt;
  dotq_pkg::delay_t  idle_r;

  dotq_pkg::status_t res_status_r, res_status_nxt;
  dotq_pkg::id_t     res_id_r, res_id_nxt;
  dotq_pkg::tstamp_t res_ftime_r, res_ftime_nxt;
  dotq_pkg::tstamp_t res_delay_r, res_delay_nxt;

  logic              out_valid_r;
  dotq_pkg::status_t out_status_r;
  dotq_pkg::id_t     out_id_r;
  dotq_pkg::tstamp_t out_ftime_r;
  dotq_pkg::tstamp_t out_delay_r;

  dotq_pkg::cnt_t    rd_off;
  dotq_pkg::idx_t    rd_addr;
  dotq_pkg::idx_t    wr_addr;
  dotq_pkg::entry_t  wr_data;
  logic              fire;
  logic              pop;

  assign in_chan.ready  = cmd_i.in_ready;
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid      = out_valid_r;
  assign out_chan.status     = out_status_r;
  assign out_chan.fired_id   = out_id_r;
  assign out_chan.fired_time = out_ftime_r;
  assign out_chan.wait_delay = out_delay_r;

  always_comb begin
    if (cmd_i.ld_item) begin
      k_nxt = cnt_r;
    end else if (cmd_i.k_dec) begin
      k_nxt = k_r - dotq_pkg::CNT_W'(1);
    end else begin
      k_nxt = k_r;
    end
  end

  assign rd_off  = cmd_i.rd_head ? '0 : k_nxt - dotq_pkg::CNT_W'(1);
  assign rd_addr = dotq_pkg::wrap_idx(head_r, rd_off);
  assign wr_addr = dotq_pkg::wrap_idx(head_r, k_r);
  assign wr_data = cmd_i.wr_item ? dotq_pkg::entry_t'({item_dl_r, item_tag_r}) : rd_r;

  // zero deadline fires at any time
  assign fire = (rd_r.dl == '0) || (rd_r.dl <= item_now_r);
  assign pop  = cmd_i.res_ld && (cmd_i.res_kind == dotq_pkg::RK_POLL) && fire;

  always_comb begin
    cnt_nxt  = cnt_r;
    head_nxt = head_r;
    if (cmd_i.cnt_inc) begin
      cnt_nxt = cnt_r + dotq_pkg::CNT_W'(1);
    end else if (pop) begin
      cnt_nxt  = cnt_r - dotq_pkg::CNT_W'(1);
      head_nxt = dotq_pkg::wrap_idx(head_r, dotq_pkg::CNT_W'(1));
    end
  end

  always_comb begin
    res_status_nxt = dotq_pkg::ST_ADDED;
    res_id_nxt     = '0;
    res_ftime_nxt  = '0;
    res_delay_nxt  = '0;
    unique case (cmd_i.res_kind)
      dotq_pkg::RK_ADDED: begin
        res_status_nxt = dotq_pkg::ST_ADDED;
      end
      dotq_pkg::RK_FULL: begin
        res_status_nxt = dotq_pkg::ST_FULL;
      end
      dotq_pkg::RK_IDLE: begin
        res_status_nxt = dotq_pkg::ST_WAIT;
        res_delay_nxt  = dotq_pkg::TIME_W'(idle_r);
      end
      dotq_pkg::RK_POLL: begin
        if (fire) begin
          res_status_nxt = dotq_pkg::ST_FIRED;
          res_id_nxt     = dotq_pkg::tag_to_id(rd_r.tag);
          res_ftime_nxt  = (rd_r.dl == '0) ? '0 : item_now_r;
        end else begin
          res_status_nxt = dotq_pkg::ST_WAIT;
          res_delay_nxt  = rd_r.dl - item_now_r;
        end
      end
      default: begin
        res_status_nxt = dotq_pkg::ST_ADDED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      head_r      <= '0;
      k_r         <= '0;
      idle_r      <= dotq_pkg::IDLE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      head_r <= head_nxt;
      k_r    <= k_nxt;
      if (cfg_chan.valid) begin
        idle_r <= cfg_chan.data;
      end
      if (cmd_i.out_push) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.ld_item) begin
      item_cmd_r <= in_chan.cmd;
      item_dl_r  <= in_chan.deadline;
      item_tag_r <= dotq_pkg::id_to_tag(in_chan.event_id);
      item_now_r <= in_chan.now_time;
    end
    if (cmd_i.res_ld) begin
      res_status_r <= res_status_nxt;
      res_id_r     <= res_id_nxt;
      res_ftime_r  <= res_ftime_nxt;
      res_delay_r  <= res_delay_nxt;
    end
    if (cmd_i.out_push) begin
      out_status_r <= res_status_r;
      out_id_r     <= res_id_r;
      out_ftime_r  <= res_ftime_r;
      out_delay_r  <= res_delay_r;
    end
  end

  assign sts_o.in_valid  = in_chan.valid;
  assign sts_o.item_poll = (item_cmd_r == dotq_pkg::CMD_POLL);
  assign sts_o.cnt_zero  = (cnt_r == '0);
  assign sts_o.full      = (cnt_r == dotq_pkg::CNT_W'(dotq_pkg::QUEUE_DEPTH));
  assign sts_o.k_one     = (k_r == dotq_pkg::CNT_W'(1));
  assign sts_o.rd_gt     = (rd_r.dl > item_dl_r);
  assign sts_o.out_free  = !out_valid_r || out_chan.ready;

endmodule

// ===== rtl/deadline_ordered_timer_queue.sv =====
// deadline-ordered timer queue, up to 16 entries kept sorted by deadline
// in_chan: one transaction per request; cmd add stores deadline/event_id
//   behind every entry with an equal or earlier deadline, cmd poll checks
//   the head against now_time and fires it or reports the time left
// out_chan: exactly one result transaction per request, in request order
// cfg_chan: writes idle_delay (reported by a poll of an empty queue);
//   always ready, write only while no request is in flight
// an add walks from the tail toward the head over the entry memory, moving
//   each stored entry with a later deadline up one slot; an add into an
//   empty or a full queue skips the walk, and a poll of an empty queue
//   skips the read of the head entry
// one request is worked on at a time; in_chan.ready is high only while
//   the controller idles, which it reenters once its result moves into
//   the output register; the next request is accepted while the previous
//   result still sits in the output register
// reset empties the queue and restores idle_delay to 30 s; the entry
//   memory itself is not cleared
// a stalled out_chan holds its result; a following request is then
//   processed and waits until the output register frees up
module deadline_ordered_timer_queue (
  input logic        clk,
  input logic        rst_n,
  dotq_in_if.sink    in_chan,
  dotq_out_if.source out_chan,
  dotq_cfg_if.sink   cfg_chan
);

  dotq_pkg::ctrl_cmd_t ctrl_cmd;
  dotq_pkg::ctrl_sts_t ctrl_sts;

  dotq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts_i (ctrl_sts),
    .cmd_o (ctrl_cmd)
  );

  dotq_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_i    (ctrl_cmd),
    .sts_o    (ctrl_sts),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

endmodule

// ===== rtl/dotq_checker.sv =====
module dotq_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input dotq_pkg::status_t out_status,
  input dotq_pkg::id_t     out_fired_id,
  input dotq_pkg::tstamp_t out_fired_time,
  input dotq_pkg::tstamp_t out_wait_delay
);

  // one request in flight: ready drops right after a transaction
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_fired_id) && $stable(out_fired_time) && $stable(out_wait_delay))
    else $error("stalled result changed");

  a_add_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == dotq_pkg::ST_ADDED || out_status == dotq_pkg::ST_FULL)
      |-> out_fired_id == '0 && out_fired_time == '0 && out_wait_delay == '0)
    else $error("add result carries nonzero fields");

  a_fired_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == dotq_pkg::ST_FIRED |-> out_wait_delay == '0)
    else $error("fired result carries a delay");

  a_wait_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == dotq_pkg::ST_WAIT
      |-> out_fired_id == '0 && out_fired_time == '0)
    else $error("waiting result carries fired fields");

endmodule

bind deadline_ordered_timer_queue dotq_checker u_dotq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_status     (out_chan.status),
  .out_fired_id   (out_chan.fired_id),
  .out_fired_time (out_chan.fired_time),
  .out_wait_delay (out_chan.wait_delay)
);
